// ----- sv/coap_mp_pkg.sv -----
// Package for the CoAP message parser: item types, byte kinds and framing constants.
package coap_mp_pkg;

  localparam int MAX_MESSAGE_BYTES_DEF = 1024;

  localparam logic [3:0]  NIB_EXT1   = 4'd13;
  localparam logic [3:0]  NIB_EXT2   = 4'd14;
  localparam logic [3:0]  NIB_BAD    = 4'd15;
  localparam logic [16:0] EXT1_BASE  = 17'd13;
  localparam logic [16:0] EXT2_BASE  = 17'd269;
  localparam logic [7:0]  MARKER     = 8'hFF;

  typedef enum logic [2:0] {
    K_HDR    = 3'd0,
    K_TOK    = 3'd1,
    K_OPTHDR = 3'd2,
    K_EXT    = 3'd3,
    K_VAL    = 3'd4,
    K_MARK   = 3'd5,
    K_PAY    = 3'd6,
    K_BAD    = 3'd7
  } byte_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    byte_kind_t  byte_kind;
    logic [7:0]  byte_value;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [7:0]  option_count;
    logic [1:0]  msg_version;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [7:0]  msg_code;
    logic [15:0] message_id;
    logic [9:0]  payload_offset;
    logic        message_done;
  } out_item_t;

endpackage

// ----- sv/coap_message_parser.sv -----
// CoAP message parser: tags each message byte and decodes header and option fields.
//
// Usage: one message byte per input item on in_data, with end_of_packet set on
// the last byte of a message. Every input item yields exactly one result item on
// out_data: the byte kind, the byte itself, the running option number, length
// and count, the decoded header fields and the payload offset.
// Both channels use valid/stall; an item moves on an edge where valid is high
// and stall is low.
// Pipeline: an input register and a result register with the phase machine in
// between. Throughput is one item per cycle while out_stall does not hold a
// result.
// When out_stall holds a result, an item can still be taken into an empty input
// register; in_stall rises once the input register holds an item.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the header phase. After the result of an end_of_packet byte the parser
// state returns to reset, so the next byte starts a new message.
// Bytes at offset MAX_MESSAGE_BYTES and beyond are tagged malformed.
module coap_message_parser #(
  parameter int MAX_MESSAGE_BYTES = coap_mp_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  coap_mp_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output coap_mp_pkg::out_item_t out_data
);
  import coap_mp_pkg::*;

  localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int PW    = (OFF_W + 1 > 10) ? OFF_W + 1 : 10;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_OPTHDR,
    PH_EXT,
    PH_VALUE,
    PH_PAYLOAD,
    PH_BAD
  } phase_t;

  function automatic logic [1:0] ext_bytes(input logic [3:0] nib);
    return (nib == NIB_EXT1) ? 2'd1 : ((nib == NIB_EXT2) ? 2'd2 : 2'd0);
  endfunction

  function automatic logic [16:0] ext_base(input logic [3:0] nib);
    return (nib == NIB_EXT1) ? EXT1_BASE : EXT2_BASE;
  endfunction

  // pipeline registers
  logic      v1_r;
  in_item_t  in_r;
  logic      out_valid_r;
  out_item_t out_r;
  logic      adv;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [3:0]  tok_r, tok_nxt;
  logic [1:0]  epd_r, epd_nxt;
  logic [1:0]  epl_r, epl_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [16:0] vr_r, vr_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [9:0]  ps_r, ps_nxt;
  logic [3:0]  dn_r, dn_nxt;
  logic [3:0]  ln_r, ln_nxt;
  logic [16:0] cur_r, cur_nxt;

  byte_kind_t  kind;
  out_item_t   res;
  logic [7:0]  b;
  logic        eop;
  logic        fail;
  logic [15:0] acc_shift;
  logic [16:0] d;
  logic [17:0] sum_try;
  logic [PW-1:0] ps_wide;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = v1_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    b         = in_r.data_byte;
    eop       = in_r.end_of_packet;
    kind      = K_BAD;
    fail      = 1'b0;
    acc_shift = {acc_r[7:0], b};
    d         = {1'b0, acc_shift} + ext_base(dn_r);
    sum_try   = '0;
    ps_wide   = PW'(off_r) + PW'(1);

    phase_nxt = phase_r;
    off_nxt   = off_r;
    hdr_nxt   = hdr_r;
    tok_nxt   = tok_r;
    epd_nxt   = epd_r;
    epl_nxt   = epl_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    vr_nxt    = vr_r;
    cnt_nxt   = cnt_r;
    ps_nxt    = ps_r;
    dn_nxt    = dn_r;
    ln_nxt    = ln_r;
    cur_nxt   = cur_r;

    if (off_r >= OFF_W'(MAX_MESSAGE_BYTES)) begin
      phase_nxt = PH_BAD;
    end else begin
      off_nxt = off_r + OFF_W'(1);
      unique case (phase_r)
        PH_HEADER: begin
          kind = K_HDR;
          unique case (off_r[1:0])
            2'd0: hdr_nxt[31:24] = hdr_r[31:24] | b;
            2'd1: hdr_nxt[23:16] = hdr_r[23:16] | b;
            2'd2: hdr_nxt[15:8]  = hdr_r[15:8] | b;
            default: hdr_nxt[7:0] = hdr_r[7:0] | b;
          endcase
          if (off_r[1:0] == 2'd3) begin
            tok_nxt   = hdr_r[27:24];
            phase_nxt = (hdr_r[27:24] != 4'd0) ? PH_TOKEN : PH_OPTHDR;
          end
        end
        PH_TOKEN: begin
          kind    = K_TOK;
          tok_nxt = tok_r - 4'd1;
          if (tok_nxt == 4'd0) phase_nxt = PH_OPTHDR;
        end
        PH_OPTHDR: begin
          if (b == MARKER) begin
            kind      = K_MARK;
            phase_nxt = PH_PAYLOAD;
            ps_nxt    = ps_wide[9:0];
          end else begin
            dn_nxt = b[7:4];
            ln_nxt = b[3:0];
            if (b[7:4] == NIB_BAD || b[3:0] == NIB_BAD) begin
              phase_nxt = PH_BAD;
            end else begin
              kind = K_OPTHDR;
              if (cnt_r != 8'hFF) cnt_nxt = cnt_r + 8'd1;
              epd_nxt = ext_bytes(b[7:4]);
              epl_nxt = ext_bytes(b[3:0]);
              acc_nxt = '0;
              cur_nxt = (b[3:0] < NIB_EXT1) ? {13'b0, b[3:0]} : '0;
              if (epd_nxt == 2'd0) begin
                sum_try = {2'b0, sum_r} + {14'b0, b[7:4]};
                if (sum_try[17:16] != 2'b00) begin
                  sum_nxt = 16'hFFFF;
                  fail    = 1'b1;
                end else begin
                  sum_nxt = sum_try[15:0];
                end
              end
              if (fail) begin
                kind      = K_BAD;
                phase_nxt = PH_BAD;
              end else if (epd_nxt == 2'd0 && epl_nxt == 2'd0) begin
                vr_nxt    = cur_nxt;
                phase_nxt = (cur_nxt != '0) ? PH_VALUE : PH_OPTHDR;
              end else begin
                phase_nxt = PH_EXT;
              end
            end
          end
        end
        PH_EXT: begin
          kind    = K_EXT;
          acc_nxt = acc_shift;
          if (epd_r != 2'd0) begin
            epd_nxt = epd_r - 2'd1;
            if (epd_nxt == 2'd0) begin
              acc_nxt = '0;
              sum_try = {2'b0, sum_r} + {1'b0, d};
              if (sum_try[17:16] != 2'b00) begin
                sum_nxt = 16'hFFFF;
                fail    = 1'b1;
              end else begin
                sum_nxt = sum_try[15:0];
              end
            end
          end else if (epl_r != 2'd0) begin
            epl_nxt = epl_r - 2'd1;
            if (epl_nxt == 2'd0) begin
              cur_nxt = {1'b0, acc_shift} + ext_base(ln_r);
              acc_nxt = '0;
            end
          end
          if (fail) begin
            kind      = K_BAD;
            phase_nxt = PH_BAD;
          end else if (epd_nxt == 2'd0 && epl_nxt == 2'd0) begin
            vr_nxt    = cur_nxt;
            phase_nxt = (cur_nxt != '0) ? PH_VALUE : PH_OPTHDR;
          end
        end
        PH_VALUE: begin
          kind   = K_VAL;
          vr_nxt = vr_r - 17'd1;
          if (vr_nxt == '0) phase_nxt = PH_OPTHDR;
        end
        PH_PAYLOAD: kind = K_PAY;
        default: phase_nxt = PH_BAD;
      endcase
    end

    // truncated message or marker with no payload
    if (eop && kind != K_BAD) begin
      if (kind == K_MARK || phase_nxt == PH_HEADER || phase_nxt == PH_TOKEN ||
          phase_nxt == PH_EXT || phase_nxt == PH_VALUE) begin
        kind = K_BAD;
      end
    end

    res.byte_kind      = kind;
    res.byte_value     = b;
    res.option_number  = sum_nxt;
    res.option_length  = cur_nxt;
    res.option_count   = cnt_nxt;
    res.msg_version    = hdr_nxt[31:30];
    res.msg_type       = hdr_nxt[29:28];
    res.token_len      = hdr_nxt[27:24];
    res.msg_code       = hdr_nxt[23:16];
    res.message_id     = hdr_nxt[15:0];
    res.payload_offset = ps_nxt;
    res.message_done   = eop;

    if (eop) begin
      phase_nxt = PH_HEADER;
      off_nxt   = '0;
      hdr_nxt   = '0;
      tok_nxt   = '0;
      epd_nxt   = '0;
      epl_nxt   = '0;
      acc_nxt   = '0;
      sum_nxt   = '0;
      vr_nxt    = '0;
      cnt_nxt   = '0;
      ps_nxt    = '0;
      dn_nxt    = '0;
      ln_nxt    = '0;
      cur_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEADER;
      off_r       <= '0;
      hdr_r       <= '0;
      tok_r       <= '0;
      epd_r       <= '0;
      epl_r       <= '0;
      acc_r       <= '0;
      sum_r       <= '0;
      vr_r        <= '0;
      cnt_r       <= '0;
      ps_r        <= '0;
      dn_r        <= '0;
      ln_r        <= '0;
      cur_r       <= '0;
    end else begin
      if (adv) out_valid_r <= v1_r;
      if (adv && v1_r) begin
        out_r   <= res;
        phase_r <= phase_nxt;
        off_r   <= off_nxt;
        hdr_r   <= hdr_nxt;
        tok_r   <= tok_nxt;
        epd_r   <= epd_nxt;
        epl_r   <= epl_nxt;
        acc_r   <= acc_nxt;
        sum_r   <= sum_nxt;
        vr_r    <= vr_nxt;
        cnt_r   <= cnt_nxt;
        ps_r    <= ps_nxt;
        dn_r    <= dn_nxt;
        ln_r    <= ln_nxt;
        cur_r   <= cur_nxt;
      end
      if (!in_stall) begin
        v1_r <= in_valid;
        if (in_valid) in_r <= in_data;
      end
    end
  end

  // parser is back at message start after a last byte is processed
  a_eop_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v1_r && in_r.end_of_packet) |=> (phase_r == PH_HEADER && off_r == '0))
    else $error("parser state not cleared after end of message");

  // header bytes come before any option or payload marker
  a_hdr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.byte_kind == K_HDR) |->
      (out_r.option_count == 8'd0 && out_r.payload_offset == 10'd0))
    else $error("header byte reported with option or payload state");

  // input side stalls only with a held item and a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && out_valid_r && out_stall))
    else $error("in_stall without a blocked result");

endmodule
